[hdl/tlbpt_pkg.sv]
// Shared types and fixed widths for the TLB page-table translator.
// No dependencies; imported by tlbpt_tlb, the top level, the checker and the testbench.
package tlbpt_pkg;

    // Fixed port widths
    localparam int ADDR_W = 16;
    localparam int FILL_W = 8;
    localparam int CNT_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

endpackage : tlbpt_pkg

[hdl/tlbpt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tlbpt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : tlbpt_ram

[hdl/tlbpt_tlb.sv]
// Fully associative TLB with true LRU ages held in flops, one lane per entry.
// Depends on tlbpt_pkg (imported for house consistency).
module tlbpt_tlb #(
    parameter int ENTRIES = 16,
    parameter int PAGE_W  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PAGE_W-1:0] i_page,
    input  logic              i_commit,
    input  logic [PAGE_W-1:0] i_fill_frame,
    output logic              o_hit,
    output logic [PAGE_W-1:0] o_frame
);
    import tlbpt_pkg::*;

    localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(ENTRIES - 1);

    logic [ENTRIES-1:0]             r_valid;
    logic [ENTRIES-1:0][PAGE_W-1:0] r_page;
    logic [ENTRIES-1:0][PAGE_W-1:0] r_frame;
    logic [ENTRIES-1:0][AGE_W-1:0]  r_age;

    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_free_sel;
    logic [ENTRIES-1:0] w_oldest_sel;
    logic [ENTRIES-1:0] w_sel;
    logic               w_found;
    logic               w_any_free;
    logic [AGE_W-1:0]   w_hit_age;
    logic [AGE_W-1:0]   w_old_age;
    logic               w_age_all;

    // Lookup: pages are unique in the TLB, so an OR of matching lanes is enough
    always_comb begin
        o_frame   = '0;
        w_hit_age = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_page[i] == i_page);
            if (w_match[i]) begin
                o_frame   = o_frame | r_frame[i];
                w_hit_age = w_hit_age | r_age[i];
            end
        end
        o_hit = |w_match;
    end

    // Victim: lowest free lane, else the lane holding the oldest age.
    // Valid ages always form 0..k-1, so a full TLB has exactly one oldest lane.
    always_comb begin
        w_free_sel = '0;
        w_found    = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_oldest_sel[i] = r_age[i] == AGE_OLDEST;
            if (!r_valid[i] && !w_found) begin
                w_free_sel[i] = 1'b1;
                w_found       = 1'b1;
            end
        end
        w_any_free = w_found;
    end

    // Touched lane and the age threshold below which other lanes get older
    always_comb begin
        if (o_hit) begin
            w_sel     = w_match;
            w_old_age = w_hit_age;
            w_age_all = 1'b0;
        end else if (w_any_free) begin
            w_sel     = w_free_sel;
            w_old_age = AGE_OLDEST;
            w_age_all = 1'b1;
        end else begin
            w_sel     = w_oldest_sel;
            w_old_age = AGE_OLDEST;
            w_age_all = 1'b0;
        end
    end

    // Entry update on commit: refresh on hit, refill on miss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_sel[i]) begin
                    r_valid[i] <= 1'b1;
                    r_age[i]   <= '0;
                    if (!o_hit) begin
                        r_page[i]  <= i_page;
                        r_frame[i] <= i_fill_frame;
                    end
                end else if (r_valid[i] && (w_age_all || (r_age[i] < w_old_age))) begin
                    r_age[i] <= r_age[i] + AGE_W'(1);
                end
            end
        end
    end

endmodule : tlbpt_tlb

[hdl/tlb_page_table_translator_top.sv]
// Top level of the TLB page-table translator: controller, page table RAM, TLB.
// Depends on tlbpt_pkg, tlbpt_ram and tlbpt_tlb.

// One logical address is taken per start while busy is low; its result is
// registered at the end of the lookup state and shown for exactly one cycle,
// marked by o_done, and the receiver cannot stall it. The idle state issues
// the registered page-table RAM read; the lookup state searches the TLB,
// resolves the frame and writes the page-table entry and TLB lane back; busy
// is high in the lookup state and low again as o_done rises, so a new word may
// be started in the same cycle the result is shown. After reset the block
// sweeps the page table clear with busy high before the first word is taken.
// PAGE_COUNT and PAGE_BYTES must be powers of two. o_hit_total and
// o_fault_total are saturating and already include the word shown with o_done.
module tlb_page_table_translator_top #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int PAGE_BYTES  = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tlbpt_pkg::ADDR_W-1:0] i_logical_address,
    output logic                        o_done,
    output logic [tlbpt_pkg::ADDR_W-1:0] o_physical_address,
    output logic                        o_tlb_hit,
    output logic                        o_page_fault,
    output logic [tlbpt_pkg::FILL_W-1:0] o_fill_page,
    output logic [tlbpt_pkg::FILL_W-1:0] o_fill_frame,
    output logic [tlbpt_pkg::CNT_W-1:0]  o_hit_total,
    output logic [tlbpt_pkg::CNT_W-1:0]  o_fault_total
);
    import tlbpt_pkg::*;

    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int OFFS_W = $clog2(PAGE_BYTES);
    localparam int ENT_W  = PAGE_W + 1;
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);

    // Registers
    t_state             r_state,      n_state;
    logic [PAGE_W-1:0]  r_clr_idx,    n_clr_idx;
    logic [PAGE_W-1:0]  r_page,       n_page;
    logic [OFFS_W-1:0]  r_offset,     n_offset;
    logic [PAGE_W-1:0]  r_next_free,  n_next_free;
    logic [CNT_W-1:0]   r_hit_cnt,    n_hit_cnt;
    logic [CNT_W-1:0]   r_fault_cnt,  n_fault_cnt;
    logic               r_done,       n_done;
    logic [ADDR_W-1:0]  r_phys,       n_phys;
    logic               r_hit,        n_hit;
    logic               r_fault,      n_fault;
    logic [FILL_W-1:0]  r_fill_page,  n_fill_page;
    logic [FILL_W-1:0]  r_fill_frame, n_fill_frame;

    // Address split and datapath wires
    logic [ADDR_W+PAGE_W-1:0]        w_addr_ext;
    logic [PAGE_W-1:0]               w_in_page;
    logic [ENT_W-1:0]                w_ram_rdata;
    logic                            w_ram_we;
    logic [PAGE_W-1:0]               w_ram_waddr;
    logic [ENT_W-1:0]                w_ram_wdata;
    logic                            w_tlb_hit;
    logic [PAGE_W-1:0]               w_tlb_frame;
    logic                            w_tlb_commit;
    logic                            w_fault;
    logic [PAGE_W-1:0]               w_miss_frame;
    logic [PAGE_W-1:0]               w_frame;
    logic [ADDR_W+PAGE_W+OFFS_W-1:0] w_phys_ext;
    logic [PAGE_W+FILL_W-1:0]        w_page_ext;
    logic [PAGE_W+FILL_W-1:0]        w_frame_ext;

    assign w_addr_ext = {{PAGE_W{1'b0}}, i_logical_address};
    assign w_in_page  = w_addr_ext[OFFS_W +: PAGE_W];

    // Page table: {valid, frame} per page
    tlbpt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_in_page),
        .o_rdata (w_ram_rdata)
    );

    tlbpt_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PAGE_W)
    ) u_tlb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_page       (r_page),
        .i_commit     (w_tlb_commit),
        .i_fill_frame (w_miss_frame),
        .o_hit        (w_tlb_hit),
        .o_frame      (w_tlb_frame)
    );

    // Frame resolution for the word in the lookup cycle
    assign w_fault      = !w_tlb_hit && !w_ram_rdata[PAGE_W];
    assign w_miss_frame = w_ram_rdata[PAGE_W] ? w_ram_rdata[PAGE_W-1:0] : r_next_free;
    assign w_frame      = w_tlb_hit ? w_tlb_frame : w_miss_frame;
    assign w_phys_ext   = {{ADDR_W{1'b0}}, w_frame, r_offset};
    assign w_page_ext   = {{FILL_W{1'b0}}, r_page};
    assign w_frame_ext  = {{FILL_W{1'b0}}, r_next_free};

    // Next state and outputs
    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_page       = r_page;
        n_offset     = r_offset;
        n_next_free  = r_next_free;
        n_hit_cnt    = r_hit_cnt;
        n_fault_cnt  = r_fault_cnt;
        n_done       = 1'b0;
        n_phys       = r_phys;
        n_hit        = r_hit;
        n_fault      = r_fault;
        n_fill_page  = r_fill_page;
        n_fill_frame = r_fill_frame;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_page;
        w_ram_wdata  = {1'b1, r_next_free};
        w_tlb_commit = 1'b0;
        busy         = 1'b1;

        case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_idx;
                w_ram_wdata = '0;
                n_clr_idx   = r_clr_idx + PAGE_W'(1);
                if (r_clr_idx == LAST_PAGE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy     = 1'b0;
                n_page   = w_in_page;
                n_offset = i_logical_address[OFFS_W-1:0];
                if (start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                w_tlb_commit = 1'b1;
                w_ram_we     = w_fault;
                n_done       = 1'b1;
                n_hit        = w_tlb_hit;
                n_fault      = w_fault;
                n_phys       = w_phys_ext[ADDR_W-1:0];
                n_fill_page  = w_fault ? w_page_ext[FILL_W-1:0] : '0;
                n_fill_frame = w_fault ? w_frame_ext[FILL_W-1:0] : '0;
                if (w_tlb_hit && (r_hit_cnt != CNT_MAX)) begin
                    n_hit_cnt = r_hit_cnt + CNT_W'(1);
                end
                if (w_fault) begin
                    n_next_free = r_next_free + PAGE_W'(1);
                    if (r_fault_cnt != CNT_MAX) begin
                        n_fault_cnt = r_fault_cnt + CNT_W'(1);
                    end
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_next_free <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_next_free <= n_next_free;
            r_hit_cnt   <= n_hit_cnt;
            r_fault_cnt <= n_fault_cnt;
            r_done      <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_page       <= n_page;
        r_offset     <= n_offset;
        r_phys       <= n_phys;
        r_hit        <= n_hit;
        r_fault      <= n_fault;
        r_fill_page  <= n_fill_page;
        r_fill_frame <= n_fill_frame;
    end

    assign o_done             = r_done;
    assign o_physical_address = r_phys;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_fill_page        = r_fill_page;
    assign o_fill_frame       = r_fill_frame;
    assign o_hit_total        = r_hit_cnt;
    assign o_fault_total      = r_fault_cnt;

endmodule : tlb_page_table_translator_top

[hdl/tlbpt_checker.sv]
// Port-level assertions for the TLB page-table translator, bound to the top.
// Depends on tlbpt_pkg and tlb_page_table_translator_top.
module tlbpt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [tlbpt_pkg::ADDR_W-1:0] i_logical_address,
    input logic                         o_done,
    input logic [tlbpt_pkg::ADDR_W-1:0] o_physical_address,
    input logic                         o_tlb_hit,
    input logic                         o_page_fault,
    input logic [tlbpt_pkg::FILL_W-1:0] o_fill_page,
    input logic [tlbpt_pkg::FILL_W-1:0] o_fill_frame,
    input logic [tlbpt_pkg::CNT_W-1:0]  o_hit_total,
    input logic [tlbpt_pkg::CNT_W-1:0]  o_fault_total
);
    import tlbpt_pkg::*;

    // An accepted word is followed by busy and then by a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 o_done)
        else $error("accepted word produced no result");

    // A hit never allocates a frame
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_tlb_hit && o_page_fault))
        else $error("hit and fault flagged together");

    // Fill fields are zero without a fault
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_page_fault) |-> (o_fill_page == '0) && (o_fill_frame == '0))
        else $error("fill fields set without a fault");

    // Hit total moves only with a hit result
    a_hit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_hit_total) |-> (o_done && o_tlb_hit))
        else $error("hit total changed without a hit");

    // Fault total moves only with a fault result
    a_fault_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_fault_total) |-> (o_done && o_page_fault))
        else $error("fault total changed without a fault");

endmodule : tlbpt_checker

bind tlb_page_table_translator_top tlbpt_checker u_tlbpt_checker (.*);

[dv/tb.sv]
// Self-checking testbench for tlb_page_table_translator_top: directed and random addresses.
// A predictor in this file tracks TLB, page table and allocator; depends on tlbpt_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbpt_pkg::*;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int PAGE_BYTES  = 256;
    localparam int ADDR_MASK   = (1 << ADDR_W) - 1;
    localparam int FLUSH_CYCLES = 8;

    // Expected translation result
    typedef struct {
        logic [ADDR_W-1:0] phys;
        logic              hit;
        logic              fault;
        logic [FILL_W-1:0] fill_page;
        logic [FILL_W-1:0] fill_frame;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  fault_total;
    } t_xlat;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [ADDR_W-1:0]   i_logical_address;
    logic                o_done;
    logic [ADDR_W-1:0]   o_physical_address;
    logic                o_tlb_hit;
    logic                o_page_fault;
    logic [FILL_W-1:0]   o_fill_page;
    logic [FILL_W-1:0]   o_fill_frame;
    logic [CNT_W-1:0]    o_hit_total;
    logic [CNT_W-1:0]    o_fault_total;

    // Shadow TLB, page table and allocator
    logic              ent_valid [TLB_ENTRIES];
    logic [FILL_W-1:0] ent_page  [TLB_ENTRIES];
    logic [FILL_W-1:0] ent_frame [TLB_ENTRIES];
    logic [3:0]        ent_age   [TLB_ENTRIES];
    logic              pt_valid  [PAGE_COUNT];
    logic [FILL_W-1:0] pt_frame  [PAGE_COUNT];
    logic [FILL_W-1:0] alloc_frame;
    logic [CNT_W-1:0]  hits_seen;
    logic [CNT_W-1:0]  faults_seen;

    t_xlat pending_xlat[$];
    int    mismatches;
    int    idle_pct;

    tlb_page_table_translator_top #(
        .TLB_ENTRIES(TLB_ENTRIES),
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_logical_address  (i_logical_address),
        .o_done             (o_done),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_fill_page        (o_fill_page),
        .o_fill_frame       (o_fill_frame),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Make entry e the most recent; entries younger than old_age grow older
    function automatic void promote_entry(int e, int old_age);
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (i != e && ent_valid[i] && int'(ent_age[i]) < old_age)
                ent_age[i] = ent_age[i] + 4'd1;
        end
        ent_age[e] = '0;
    endfunction

    // Translate one address against the shadow state and advance it
    function automatic t_xlat translate_address(logic [ADDR_W-1:0] addr);
        t_xlat r;
        int offset, page, frame, victim, old_age;
        logic hit, fault;
        offset = int'(addr) % PAGE_BYTES;
        page   = (int'(addr) / PAGE_BYTES) % PAGE_COUNT;
        frame  = 0;
        hit    = 1'b0;
        fault  = 1'b0;
        r.fill_page  = '0;
        r.fill_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && ent_valid[i] && int'(ent_page[i]) == page) begin
                hit   = 1'b1;
                frame = int'(ent_frame[i]);
                promote_entry(i, int'(ent_age[i]));
            end
        end
        if (hit) begin
            if (hits_seen != CNT_MAX) hits_seen = hits_seen + 1;
        end else begin
            if (pt_valid[page]) begin
                frame = int'(pt_frame[page]);
            end else begin
                // demand fill from the wrapping allocator
                fault          = 1'b1;
                frame          = int'(alloc_frame) % PAGE_COUNT;
                pt_frame[page] = FILL_W'(frame);
                pt_valid[page] = 1'b1;
                r.fill_page    = FILL_W'(page);
                r.fill_frame   = FILL_W'(frame);
                alloc_frame    = FILL_W'((frame + 1) % PAGE_COUNT);
                if (faults_seen != CNT_MAX) faults_seen = faults_seen + 1;
            end
            // lowest invalid lane first, else oldest, lowest index on a tie
            victim = -1;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (victim < 0 && !ent_valid[i]) victim = i;
            end
            if (victim < 0) begin
                victim = 0;
                for (int i = 1; i < TLB_ENTRIES; i++) begin
                    if (ent_age[i] > ent_age[victim]) victim = i;
                end
            end
            old_age = ent_valid[victim] ? int'(ent_age[victim]) : TLB_ENTRIES;
            ent_valid[victim] = 1'b1;
            ent_page[victim]  = FILL_W'(page);
            ent_frame[victim] = FILL_W'(frame);
            promote_entry(victim, old_age);
        end
        r.phys        = ADDR_W'((frame * PAGE_BYTES + offset) & ADDR_MASK);
        r.hit         = hit;
        r.fault       = fault;
        r.hit_total   = hits_seen;
        r.fault_total = faults_seen;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [CNT_W-1:0] exp_v,
                                          logic [CNT_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Check each result word against the oldest prediction, then predict new words
    always @(posedge i_clk) begin
        t_xlat e;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_xlat.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got phys %0h",
                             $time, o_physical_address);
                    mismatches++;
                end else begin
                    e = pending_xlat.pop_front();
                    compare_field("physical_address", CNT_W'(e.phys),
                                  CNT_W'(o_physical_address));
                    compare_field("tlb_hit", CNT_W'(e.hit), CNT_W'(o_tlb_hit));
                    compare_field("page_fault", CNT_W'(e.fault), CNT_W'(o_page_fault));
                    compare_field("fill_page", CNT_W'(e.fill_page), CNT_W'(o_fill_page));
                    compare_field("fill_frame", CNT_W'(e.fill_frame), CNT_W'(o_fill_frame));
                    compare_field("hit_total", e.hit_total, o_hit_total);
                    compare_field("fault_total", e.fault_total, o_fault_total);
                end
            end
            if (start && !busy)
                pending_xlat.push_back(translate_address(i_logical_address));
        end
    end

    // Random idle cycles before a word; address churns while start is low
    task automatic sender_gap();
        while ($urandom_range(0, 99) < idle_pct) begin
            start             <= 1'b0;
            i_logical_address <= ADDR_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Offer one word and hold it until taken
    task automatic send_word(logic [ADDR_W-1:0] addr);
        sender_gap();
        start             <= 1'b1;
        i_logical_address <= addr;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending until every predicted word has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_xlat.size() != 0);
    endtask

    // Address extremes: first fault, hit, top page, table hits after eviction later
    task automatic test_extremes();
        send_word(16'h0000);
        send_word(16'h00FF);
        send_word(16'hFFFF);
        send_word(16'hFF00);
        send_word(16'h8001);
        send_word(16'h7FFE);
    endtask

    // Fill the TLB, refresh one lane, force an LRU eviction and a table-only hit
    task automatic test_lru_eviction();
        for (int p = 1; p <= 12; p++)
            send_word(ADDR_W'((p << 8) | $urandom_range(0, 255)));
        send_word(16'h0042);
        send_word(16'h0D10);
        send_word(16'hFF80);
    endtask

    // Mostly a drifting working set for hits and evictions, the rest uniform
    task automatic test_random_traffic(int n_words, int pct);
        int base;
        int page;
        idle_pct = pct;
        base = $urandom_range(0, PAGE_COUNT - 1);
        for (int k = 0; k < n_words; k++) begin
            if ($urandom_range(0, 31) == 0)
                base = $urandom_range(0, PAGE_COUNT - 1);
            if ($urandom_range(0, 99) < 70) begin
                page = (base + $urandom_range(0, 19)) % PAGE_COUNT;
                send_word(ADDR_W'((page << 8) | $urandom_range(0, 255)));
            end else begin
                send_word(ADDR_W'($urandom));
            end
        end
        drain_results();
    endtask

    initial begin
        mismatches = 0;
        idle_pct   = 0;
        hits_seen   = '0;
        faults_seen = '0;
        alloc_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            ent_valid[i] = 1'b0;
            ent_page[i]  = '0;
            ent_frame[i] = '0;
            ent_age[i]   = '0;
        end
        for (int i = 0; i < PAGE_COUNT; i++) begin
            pt_valid[i] = 1'b0;
            pt_frame[i] = '0;
        end
        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_logical_address <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_lru_eviction();
        drain_results();

        // back-to-back, mostly idle sender, no idling, light idling
        test_random_traffic(340, 0);
        test_random_traffic(340, 80);
        test_random_traffic(340, 0);
        test_random_traffic(340, 27);

        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_xlat.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule : tb
